[rtl/ins_pkg.sv]
// Shared types and constants of the impulse noise smoother.
// Used by impulse_noise_smoother_top; depends on nothing else.
package ins_pkg;

	localparam int PIX_W      = 8;
	localparam int WREG_W     = 11;
	localparam int THR_W      = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DIFF_THRESHOLD = 2'd1;

	localparam logic [WREG_W-1:0] WIDTH_RESET = 11'd30;
	localparam logic [THR_W-1:0]  THR_RESET   = 8'd1;

	// neighbor sum and reciprocal of three for the mean
	localparam int SUM_W    = PIX_W + 2;
	localparam int RECIP_SH = SUM_W + 1;
	localparam int PROD_W   = SUM_W + RECIP_SH;
	localparam logic [RECIP_SH-1:0] RECIP3 = RECIP_SH'((1 << RECIP_SH) / 3);

	typedef struct packed {
		logic [PIX_W-1:0] pixel_value;
		logic             drain;
	} pix_beat_t;

	typedef struct packed {
		logic [PIX_W-1:0] smoothed_value;
		logic             replaced;
		logic             end_of_frame;
	} res_beat_t;

endpackage

[rtl/ins_ram.sv]
// Generic synchronous RAM: one write port, two read ports, registered read data.
// Standalone; no package needed.
module ins_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

[rtl/impulse_noise_smoother_top.sv]
// Top level of the four-neighbor impulse noise smoother.
// Depends on ins_pkg and ins_ram.
//
// Usage:
//   pix channel (pix_valid / pix_stall / pix_data) takes one raster pixel or one
//   drain beat per clock unless stalled. res channel (res_valid / res_stall / res_data)
//   gives one filtered pixel per beat, one line behind the input. Pixels of the first
//   row give no result; after the last row, one drain beat per column flushes the
//   final row, and the last drain beat carries end_of_frame. Drain beats that come
//   mid-row or before two rows are complete, and pixels sent while draining, are dropped.
//   cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data) writes image_width
//   (index 0) and diff_threshold (index 1); write only while the block is idle.
// Pipeline: a result passes the s1, s2 and s3 registers and the output register.
// Throughput: 1 beat per clock unless stalled. Each beat reads two adjacent words of
//   the line memory and each pixel beat writes one; two read ports, one write port.
// Reset: counters and flags clear, image_width = 30, diff_threshold = 1. The line
//   memory is not cleared; the first two rows of a frame fill it.
// Stall: up to four results wait in the pipeline and output register; once all are
//   full, pix_stall rises until res_stall drops.
module impulse_noise_smoother_top #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  pix_valid,
	output logic                                  pix_stall,
	input  ins_pkg::pix_beat_t                    pix_data,
	output logic                                  res_valid,
	input  logic                                  res_stall,
	output ins_pkg::res_beat_t                    res_data,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [ins_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [ins_pkg::CFG_DATA_W-1:0]        cfg_data
);

	import ins_pkg::*;

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int WID_W = $clog2(MAX_WIDTH + 1);
	localparam int CMP_W = (WID_W > WREG_W) ? WID_W : WREG_W;
	localparam int WORD_W = 2 * PIX_W;
	localparam int NB_UP = 0;
	localparam int NB_DOWN = 1;
	localparam int NB_LEFT = 2;
	localparam int NB_RIGHT = 3;

	// configuration
	logic [WREG_W-1:0] width_q;
	logic [THR_W-1:0]  thr_q;
	logic [CMP_W-1:0]  width_ext;
	logic [CMP_W-1:0]  width_clamp;
	logic [WID_W-1:0]  width_use;

	// frame state
	logic [COL_W-1:0] col_q;
	logic [1:0]       row_q;
	logic             drain_q;
	logic [PIX_W-1:0] left_q;
	logic [WID_W-1:0] col_p1;
	logic             last;
	logic [COL_W-1:0] col_d;

	// line memory and forwarding
	logic [COL_W-1:0]  raddr_b;
	logic [WORD_W-1:0] rdata_a;
	logic [WORD_W-1:0] rdata_b;
	logic [WORD_W-1:0] word_a;
	logic [WORD_W-1:0] word_b;
	logic [WORD_W-1:0] wdata;
	logic [WORD_W-1:0] wd_q;
	logic              fwd_a_q;
	logic              fwd_b_q;
	logic [PIX_W-1:0]  cen;

	// beat control
	logic accept;
	logic is_drain_item;
	logic is_pixel_item;
	logic produce;
	logic do_drain;
	logic do_pix;
	logic prod_acc;

	// pipeline
	logic             s1_v_q, s2_v_q, s3_v_q;
	logic             room_o, room3, room2, mv1, mv2, mv3;
	logic [PIX_W-1:0] cen_s1;
	logic [PIX_W-1:0] nb_s1 [4];
	logic [3:0]       has_s1;
	logic             eof_s1;

	logic [SUM_W-1:0] sum_c;
	logic [2:0]       cnt_c;
	logic             all_c;
	logic [PIX_W-1:0] dif_c [4];

	logic [SUM_W-1:0] sum_s2;
	logic [2:0]       cnt_s2;
	logic             rep_s2;
	logic [PIX_W-1:0] cen_s2;
	logic             eof_s2;

	logic [PROD_W-1:0] prod_s3;
	logic [SUM_W-1:0]  sum_s3;
	logic [2:0]        cnt_s3;
	logic              rep_s3;
	logic [PIX_W-1:0]  cen_s3;
	logic              eof_s3;

	logic [SUM_W-1:0] q3;
	logic [SUM_W:0]   q3x3;
	logic [SUM_W:0]   rem3;
	logic [SUM_W-1:0] quot;

	assign cfg_ready = 1'b1;

	always_comb begin
		width_ext = CMP_W'(width_q);
		if (width_ext < CMP_W'(2)) begin
			width_clamp = CMP_W'(2);
		end else if (width_ext > CMP_W'(MAX_WIDTH)) begin
			width_clamp = CMP_W'(MAX_WIDTH);
		end else begin
			width_clamp = width_ext;
		end
		width_use = width_clamp[WID_W-1:0];
	end

	assign col_p1 = WID_W'(col_q) + WID_W'(1);
	assign last = col_p1 >= width_use;

	assign word_a = fwd_a_q ? wd_q : rdata_a;
	assign word_b = fwd_b_q ? wd_q : rdata_b;
	assign cen = word_a[PIX_W-1:0];

	assign accept = pix_valid && !pix_stall;

	always_comb begin
		is_drain_item = 1'b0;
		is_pixel_item = 1'b0;
		if (drain_q || pix_data.drain) begin
			if (pix_data.drain && (drain_q || (col_q == '0 && row_q == 2'd2))) begin
				is_drain_item = 1'b1;
			end
		end else begin
			is_pixel_item = 1'b1;
		end
	end

	assign produce  = is_drain_item || (is_pixel_item && row_q != 2'd0);
	assign do_drain = accept && is_drain_item;
	assign do_pix   = accept && is_pixel_item;
	assign prod_acc = accept && produce;

	assign col_d = (do_drain || do_pix) ? (last ? '0 : col_p1[COL_W-1:0]) : col_q;
	assign raddr_b = (col_d == COL_W'(MAX_WIDTH - 1)) ? '0 : col_d + COL_W'(1);
	assign wdata = {cen, pix_data.pixel_value};

	ins_ram #(
		.WIDTH(WORD_W),
		.DEPTH(MAX_WIDTH)
	) u_line_ram (
		.clk    (clk),
		.we     (do_pix),
		.waddr  (col_q),
		.wdata  (wdata),
		.raddr_a(col_d),
		.rdata_a(rdata_a),
		.raddr_b(raddr_b),
		.rdata_b(rdata_b)
	);

	// pipeline flow
	assign room_o = !res_valid || !res_stall;
	assign mv3    = s3_v_q && room_o;
	assign room3  = !s3_v_q || room_o;
	assign mv2    = s2_v_q && room3;
	assign room2  = !s2_v_q || room3;
	assign mv1    = s1_v_q && room2;
	assign pix_stall = s1_v_q && !room2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WIDTH_RESET;
			thr_q   <= THR_RESET;
			col_q   <= '0;
			row_q   <= 2'd0;
			drain_q <= 1'b0;
			fwd_a_q <= 1'b0;
			fwd_b_q <= 1'b0;
			s1_v_q  <= 1'b0;
			s2_v_q  <= 1'b0;
			s3_v_q  <= 1'b0;
			res_valid <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_IMAGE_WIDTH: begin
						width_q <= cfg_data[WREG_W-1:0];
					end
					REG_DIFF_THRESHOLD: begin
						thr_q <= cfg_data[THR_W-1:0];
					end
					default: begin
					end
				endcase
			end
			col_q   <= col_d;
			fwd_a_q <= do_pix && (col_q == col_d);
			fwd_b_q <= do_pix && (col_q == raddr_b);
			if (do_pix && last && row_q != 2'd2) begin
				row_q <= row_q + 2'd1;
			end
			if (do_drain) begin
				if (last) begin
					row_q   <= 2'd0;
					drain_q <= 1'b0;
				end else begin
					drain_q <= 1'b1;
				end
			end
			if (prod_acc) begin
				s1_v_q <= 1'b1;
			end else if (mv1) begin
				s1_v_q <= 1'b0;
			end
			if (mv1) begin
				s2_v_q <= 1'b1;
			end else if (mv2) begin
				s2_v_q <= 1'b0;
			end
			if (mv2) begin
				s3_v_q <= 1'b1;
			end else if (mv3) begin
				s3_v_q <= 1'b0;
			end
			if (mv3) begin
				res_valid <= 1'b1;
			end else if (room_o) begin
				res_valid <= 1'b0;
			end
		end
	end

	// neighbor judgement
	always_comb begin
		sum_c = '0;
		cnt_c = '0;
		all_c = 1'b1;
		for (int k = 0; k < 4; k++) begin
			dif_c[k] = (cen_s1 > nb_s1[k]) ? cen_s1 - nb_s1[k] : nb_s1[k] - cen_s1;
			if (has_s1[k]) begin
				sum_c = sum_c + SUM_W'(nb_s1[k]);
				cnt_c = cnt_c + 3'd1;
				if (!(dif_c[k] > thr_q)) begin
					all_c = 1'b0;
				end
			end
		end
	end

	// mean: shift for two or four neighbors; for three, exact division: estimate, then one correction step
	always_comb begin
		q3   = prod_s3[PROD_W-1:RECIP_SH];
		q3x3 = {q3, 1'b0} + {1'b0, q3};
		rem3 = {1'b0, sum_s3} - q3x3;
		if (rem3 >= (SUM_W + 1)'(3)) begin
			q3 = q3 + SUM_W'(1);
		end
		case (cnt_s3)
			3'd2: quot = sum_s3 >> 1;
			3'd3: quot = q3;
			default: quot = sum_s3 >> 2;
		endcase
	end

	always_ff @(posedge clk) begin
		if (do_pix) begin
			wd_q <= wdata;
		end
		if (do_pix || do_drain) begin
			left_q <= cen;
		end
		if (prod_acc) begin
			cen_s1           <= cen;
			nb_s1[NB_UP]     <= word_a[WORD_W-1:PIX_W];
			nb_s1[NB_DOWN]   <= pix_data.pixel_value;
			nb_s1[NB_LEFT]   <= left_q;
			nb_s1[NB_RIGHT]  <= word_b[PIX_W-1:0];
			has_s1[NB_UP]    <= is_drain_item || row_q == 2'd2;
			has_s1[NB_DOWN]  <= !is_drain_item;
			has_s1[NB_LEFT]  <= col_q != '0;
			has_s1[NB_RIGHT] <= !last;
			eof_s1           <= is_drain_item && last;
		end
		if (mv1) begin
			sum_s2 <= sum_c;
			cnt_s2 <= cnt_c;
			rep_s2 <= all_c && cnt_c != 3'd0;
			cen_s2 <= cen_s1;
			eof_s2 <= eof_s1;
		end
		if (mv2) begin
			prod_s3 <= PROD_W'(sum_s2) * PROD_W'(RECIP3);
			sum_s3  <= sum_s2;
			cnt_s3  <= cnt_s2;
			rep_s3  <= rep_s2;
			cen_s3  <= cen_s2;
			eof_s3  <= eof_s2;
		end
		if (mv3) begin
			res_data.smoothed_value <= rep_s3 ? quot[PIX_W-1:0] : cen_s3;
			res_data.replaced       <= rep_s3;
			res_data.end_of_frame   <= eof_s3;
		end
	end

	a_col_step: assert property (@(posedge clk) disable iff (!arst_n)
		(do_pix || do_drain) && !last |=> col_q == $past(col_q) + COL_W'(1))
		else $error("column did not advance by one");

	a_drain_rows: assert property (@(posedge clk) disable iff (!arst_n)
		drain_q |-> row_q == 2'd2 && !fwd_a_q && !fwd_b_q)
		else $error("draining without two complete rows");

	a_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		prod_acc && is_drain_item && last |=> !drain_q && row_q == 2'd0 && col_q == '0)
		else $error("frame end did not clear the frame state");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		s1_v_q && s2_v_q && s3_v_q && res_valid && res_stall |-> pix_stall)
		else $error("pipeline full but input not stalled");

endmodule

[bench/impulse_noise_smoother_checker.sv]
// Checker for the impulse noise smoother: tracks register writes, predicts every
// filtered pixel from the accepted input beats and compares the result beats.
// Depends on ins_pkg.
module impulse_noise_smoother_checker #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           pix_valid,
	input  logic                           pix_stall,
	input  ins_pkg::pix_beat_t             pix_data,
	input  logic                           res_valid,
	input  logic                           res_stall,
	input  ins_pkg::res_beat_t             res_data,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [ins_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ins_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                             mismatches,
	output int                             outstanding
);
	timeunit 1ns;
	timeprecision 1ps;
	import ins_pkg::*;

	logic [PIX_W-1:0]  older_row [MAX_WIDTH];
	logic [PIX_W-1:0]  upper_row [MAX_WIDTH];
	logic [WREG_W-1:0] width_reg;
	logic [THR_W-1:0]  thr_reg;
	int unsigned       col;
	int unsigned       rows;
	bit                flushing;
	res_beat_t         pending_pixels[$];
	res_beat_t         want;
	int                idx;

	function automatic int unsigned line_len();
		if (width_reg < 2)
			return 2;
		if (width_reg > MAX_WIDTH)
			return MAX_WIDTH;
		return width_reg;
	endfunction

	// present bits: 0 up, 1 down, 2 left, 3 right
	function automatic res_beat_t filter_pixel(input logic [PIX_W-1:0] ctr,
			input bit [3:0] present, input logic [PIX_W-1:0] up,
			input logic [PIX_W-1:0] dn, input logic [PIX_W-1:0] lf,
			input logic [PIX_W-1:0] rt);
		logic [PIX_W-1:0] nb [4];
		int unsigned      sum;
		int unsigned      cnt;
		int unsigned      diff;
		int               k;
		bit               outlier;
		res_beat_t        r;
		nb[0] = up;
		nb[1] = dn;
		nb[2] = lf;
		nb[3] = rt;
		sum = 0;
		cnt = 0;
		outlier = 1'b1;
		for (k = 0; k < 4; k++) begin
			if (present[k]) begin
				sum += nb[k];
				cnt++;
				diff = (ctr > nb[k]) ? ctr - nb[k] : nb[k] - ctr;
				if (diff <= thr_reg)
					outlier = 1'b0;
			end
		end
		r.end_of_frame = 1'b0;
		if (outlier && cnt != 0) begin
			r.smoothed_value = PIX_W'(sum / cnt);
			r.replaced = 1'b1;
		end else begin
			r.smoothed_value = ctr;
			r.replaced = 1'b0;
		end
		return r;
	endfunction

	task automatic advance_stream(input pix_beat_t b);
		int unsigned w;
		int unsigned c;
		res_beat_t   r;
		w = line_len();
		c = col;
		if (flushing || b.drain) begin
			if (!flushing) begin
				if (col != 0 || rows < 2)
					return;
				flushing = 1'b1;
			end
			if (!b.drain)
				return;
			r = filter_pixel(upper_row[c], {(c + 1 < w), (c > 0), 1'b0, 1'b1},
				older_row[c], '0, (c > 0) ? upper_row[c - 1] : '0,
				(c + 1 < w) ? upper_row[c + 1] : '0);
			if (c + 1 >= w) begin
				r.end_of_frame = 1'b1;
				col = 0;
				rows = 0;
				flushing = 1'b0;
			end else begin
				col = c + 1;
			end
			pending_pixels.push_back(r);
			return;
		end
		if (rows >= 1) begin
			r = filter_pixel(upper_row[c], {(c + 1 < w), (c > 0), 1'b1, (rows >= 2)},
				older_row[c], b.pixel_value, (c > 0) ? older_row[c - 1] : '0,
				(c + 1 < w) ? upper_row[c + 1] : '0);
			pending_pixels.push_back(r);
		end
		older_row[c] = upper_row[c];
		upper_row[c] = b.pixel_value;
		if (c + 1 >= w) begin
			col = 0;
			if (rows < 2)
				rows++;
		end else begin
			col = c + 1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_reg = WIDTH_RESET;
			thr_reg = THR_RESET;
			col = 0;
			rows = 0;
			flushing = 1'b0;
			mismatches = 0;
			pending_pixels.delete();
			for (idx = 0; idx < MAX_WIDTH; idx++) begin
				older_row[idx] = '0;
				upper_row[idx] = '0;
			end
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_IMAGE_WIDTH)
					width_reg = cfg_data[WREG_W-1:0];
				else if (cfg_index == REG_DIFF_THRESHOLD)
					thr_reg = cfg_data[THR_W-1:0];
			end
			// compare before predicting: a beat taken now cannot leave now
			if (res_valid && !res_stall) begin
				if (pending_pixels.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected result beat value %0d replaced %0b eof %0b",
							$time, res_data.smoothed_value, res_data.replaced,
							res_data.end_of_frame);
				end else begin
					want = pending_pixels.pop_front();
					if (res_data.smoothed_value !== want.smoothed_value ||
							res_data.replaced !== want.replaced ||
							res_data.end_of_frame !== want.end_of_frame) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: expected %0d/%0b/%0b, got %0d/%0b/%0b", $time,
								want.smoothed_value, want.replaced, want.end_of_frame,
								res_data.smoothed_value, res_data.replaced,
								res_data.end_of_frame);
					end
				end
			end
			if (pix_valid && !pix_stall)
				advance_stream(pix_data);
		end
		outstanding = pending_pixels.size();
	end

endmodule

[bench/impulse_noise_smoother_top_tb.sv]
// Stimulus and verdict for the impulse noise smoother: directed frames, then random
// frames with register changes between them and sometimes within one. Depends on
// ins_pkg, the block and impulse_noise_smoother_checker.
module impulse_noise_smoother_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ins_pkg::*;

	localparam int MAX_WIDTH   = 1024;
	localparam int ITEM_TARGET = 1350;
	localparam int QUIET_LIMIT = 1000;
	localparam int SETTLE      = 8;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  pix_valid = 1'b0;
	logic                  pix_stall;
	pix_beat_t             pix_data = '0;
	logic                  res_valid;
	logic                  res_stall = 1'b0;
	res_beat_t             res_data;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_IMAGE_WIDTH;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	int                    mismatches;
	int                    outstanding;
	int unsigned           quiet_cycles = 0;
	int unsigned           items_sent = 0;
	int unsigned           sink_hold = 0;
	bit                    src_steady = 1'b0;
	bit                    sink_steady = 1'b0;

	impulse_noise_smoother_top #(.MAX_WIDTH(MAX_WIDTH)) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix_data  (pix_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	impulse_noise_smoother_checker #(.MAX_WIDTH(MAX_WIDTH)) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.pix_valid   (pix_valid),
		.pix_stall   (pix_stall),
		.pix_data    (pix_data),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.res_data    (res_data),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (res_valid && !res_stall) begin
			if ($urandom_range(0, 40) == 0)
				sink_steady = !sink_steady;
			sink_hold = sink_steady ? 0 : $urandom_range(0, 18);
		end else if (sink_hold != 0) begin
			sink_hold = sink_hold - 1;
		end
		res_stall <= (sink_hold != 0);
	end

	always @(posedge clk) begin
		if ((pix_valid && !pix_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("impulse_noise_smoother_top_tb: done, errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_beat(input logic [PIX_W-1:0] v, input bit drn);
		int unsigned gap;
		if ($urandom_range(0, 30) == 0)
			src_steady = !src_steady;
		gap = src_steady ? 0 : $urandom_range(0, 18);
		if (gap != 0) begin
			pix_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_valid <= 1'b1;
		pix_data.pixel_value <= v;
		pix_data.drain <= drn;
		do @(posedge clk); while (pix_stall);
	endtask

	// hold the stream until every expected beat has left, then let the pipe settle
	task automatic hold_until_drained();
		pix_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_settings(input logic [WREG_W-1:0] w_reg, input logic [THR_W-1:0] thr);
		cfg_valid <= 1'b1;
		cfg_index <= REG_IMAGE_WIDTH;
		cfg_data <= CFG_DATA_W'(w_reg);
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= REG_DIFF_THRESHOLD;
		cfg_data <= CFG_DATA_W'(thr);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_frame(input logic [WREG_W-1:0] w_reg, input logic [THR_W-1:0] thr,
			input int unsigned nrows, input int unsigned style, input bit noisy,
			input bit cut);
		int unsigned w;
		int unsigned col;
		int unsigned row;
		int unsigned level;
		int unsigned v;
		int unsigned cut_row;
		int unsigned cut_col;
		hold_until_drained();
		write_settings(w_reg, thr);
		w = (w_reg < 2) ? 2 : (w_reg > MAX_WIDTH) ? MAX_WIDTH : w_reg;
		level = $urandom_range(0, 255);
		cut_row = $urandom_range(0, nrows - 1);
		cut_col = (w > 2) ? $urandom_range(1, w - 1) : 0;
		col = 0;
		row = 0;
		while (row < nrows) begin
			if (noisy && (col != 0 || row < 2) && $urandom_range(0, 9) == 0)
				send_beat(PIX_W'($urandom_range(0, 255)), 1'b1);
			case (style)
			0: v = $urandom_range(0, 255);
			1: v = $urandom_range(0, 1) ? 255 : 0;
			default: begin
				if ($urandom_range(0, 5) == 0)
					v = $urandom_range(0, 255);
				else
					v = level + $urandom_range(0, 4);
				if (v > 255)
					v = 255;
			end
			endcase
			send_beat(PIX_W'(v), 1'b0);
			items_sent++;
			col++;
			if (col >= w) begin
				col = 0;
				row++;
			end else if (cut && w > 2 && row == cut_row && col == cut_col) begin
				hold_until_drained();
				w = $urandom_range(2, w - 1);
				write_settings(WREG_W'(w), thr);
				cut = 1'b0;
			end
		end
		for (col = 0; col < w; col++) begin
			if (noisy && col != 0 && $urandom_range(0, 7) == 0)
				send_beat(PIX_W'($urandom_range(0, 255)), 1'b0);
			send_beat(PIX_W'($urandom_range(0, 255)), 1'b1);
			items_sent++;
		end
	endtask

	initial begin
		logic [WREG_W-1:0] w_reg;
		logic [THR_W-1:0]  thr;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// narrowest line, zero threshold, early drains and a pixel while flushing
		hold_until_drained();
		write_settings(11'd0, 8'd0);
		send_beat(8'hA5, 1'b1);
		send_beat(8'h00, 1'b0);
		send_beat(8'hFF, 1'b0);
		send_beat(8'hFF, 1'b0);
		send_beat(8'h5A, 1'b1);
		send_beat(8'h00, 1'b0);
		send_beat(8'h00, 1'b0);
		send_beat(8'hFF, 1'b0);
		send_beat(8'hFF, 1'b1);
		send_beat(8'h80, 1'b0);
		send_beat(8'h00, 1'b1);

		// top threshold, width lowered in the middle of the first row
		hold_until_drained();
		write_settings(11'd5, 8'd255);
		send_beat(8'hFF, 1'b0);
		send_beat(8'h00, 1'b0);
		send_beat(8'hFF, 1'b0);
		send_beat(8'h00, 1'b0);
		hold_until_drained();
		write_settings(11'd2, 8'd255);
		send_beat(8'hFF, 1'b0);
		send_beat(8'h00, 1'b0);
		send_beat(8'hFF, 1'b0);
		send_beat(8'hFF, 1'b0);
		send_beat(8'h00, 1'b0);
		send_beat(8'h7F, 1'b1);
		send_beat(8'h80, 1'b1);

		while (items_sent < ITEM_TARGET) begin
			case ($urandom_range(0, 9))
			0: w_reg = WREG_W'($urandom_range(0, 1));
			1: w_reg = WREG_W'($urandom_range(13, 40));
			default: w_reg = WREG_W'($urandom_range(2, 10));
			endcase
			case ($urandom_range(0, 5))
			0: thr = 8'd0;
			1: thr = 8'd255;
			2: thr = 8'd254;
			default: thr = THR_W'($urandom_range(1, 12));
			endcase
			run_frame(w_reg, thr, $urandom_range(2, 7), $urandom_range(0, 2),
				$urandom_range(0, 2) != 0, $urandom_range(0, 4) == 0);
		end

		hold_until_drained();
		repeat (12) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("impulse_noise_smoother_top_tb: done, clean");
		else
			$display("impulse_noise_smoother_top_tb: done, errors");
		$finish;
	end

endmodule
